@@ src/cbq_pkg.sv @@
package cbq_pkg;

  // Store sizes.
  localparam int MAX_TRACKS  = 8;
  localparam int MAX_STAGES  = 4;
  localparam int TRK_W       = $clog2(MAX_TRACKS);
  localparam int STG_W       = $clog2(MAX_STAGES);
  localparam int CNT_W       = $clog2(MAX_STAGES + 1);
  localparam int HIST_ROWS   = MAX_TRACKS * MAX_STAGES;
  localparam int ROW_W       = $clog2(HIST_ROWS);
  localparam int COEFF_DEPTH = MAX_STAGES * 4;
  localparam int CIDX_W      = $clog2(COEFF_DEPTH);

  // Datapath widths.
  localparam int SAMPLE_W = 24;
  localparam int DATA_W   = 32;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 64;
  localparam int FRAC_W   = 28;
  localparam int TERM_W   = PROD_W - FRAC_W;
  localparam int ACC_W    = 38;
  localparam int THR_W    = 31;

  // Configuration port.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESHOLD = 3'd5;

  // Filter modes.
  localparam logic [1:0] MODE_BUTTERWORTH = 2'd0;
  localparam logic [1:0] MODE_BESSEL      = 2'd1;

  // Item operations.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEFF  = 1'b1;

  // Unity gain in Q4.28.
  localparam logic signed [DATA_W-1:0] ONE_Q28 = 32'sh1000_0000;

  typedef struct packed {
    logic                       op;
    logic [2:0]                 track;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [3:0]                 coeff_index;
    logic signed [DATA_W-1:0]   coeff_value;
    logic                       block_last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_last_out;
  } out_item_t;

  // Saturate an accumulator value to a signed 32-bit word.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
  endfunction

  // Saturate a 32-bit word to a signed 24-bit sample.
  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-SAMPLE_W:0] top;
    top = v[DATA_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return v[SAMPLE_W-1:0];
    end
    return v[DATA_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage

@@ src/cbq_mul.sv @@
module cbq_mul (
  input  logic                               clk,
  input  logic signed [cbq_pkg::MUL_W-1:0]   mul_a,
  input  logic signed [cbq_pkg::MUL_W-1:0]   mul_b,
  output logic signed [cbq_pkg::PROD_W-1:0]  prod_r
);
  import cbq_pkg::*;

  logic signed [2*MUL_W-1:0] full;

  // Signed product; every value used here fits in the low 64 bits.
  assign full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= full[PROD_W-1:0];
  end

endmodule

@@ src/cascaded_biquad_filter_top.sv @@
// Bypass and mute skip the section passes; otherwise each active section runs in turn.
// A new item is accepted only while idle, so a sample is not taken before the previous
// result is loaded into the output register; a coefficient write leaves the block idle.
// One shared 33x33 multiplier, one product per cycle: five per section, three if not Butterworth.
// Reset (synchronous, rst_n low) restores the register defaults and clears the
// history valid bits; coefficients stay undefined until written.
module cascaded_biquad_filter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cbq_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cbq_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  logic [cbq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbq_pkg::CFG_W-1:0]        cfg_wdata
);
  import cbq_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_KMUL  = 9'b000000010,
    ST_KSAT  = 9'b000000100,
    ST_KCHK  = 9'b000001000,
    ST_MAC   = 9'b000010000,
    ST_DRAIN = 9'b000100000,
    ST_WSAT  = 9'b001000000,
    ST_YSUM  = 9'b010000000,
    ST_OUTP  = 9'b100000000
  } state_t;

  // Product slots of one section, in issue order.
  localparam logic [2:0] TERM_GAIN = 3'd0;
  localparam logic [2:0] TERM_C0   = 3'd1;
  localparam logic [2:0] TERM_C1   = 3'd2;
  localparam logic [2:0] TERM_C2   = 3'd3;
  localparam logic [2:0] TERM_C3   = 3'd4;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [1:0]               mode_r;
  logic signed [DATA_W-1:0] base_gain_r;
  logic signed [DATA_W-1:0] high_gain_r;
  logic signed [DATA_W-1:0] low_gain_r;
  logic [2:0]               stage_count_r;
  logic [THR_W-1:0]         thr_r;

  // Item and working registers.
  logic [TRK_W-1:0]           trk_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic signed [MUL_W-1:0]    diff_r;
  logic signed [DATA_W-1:0]   k_r;
  logic signed [DATA_W-1:0]   y_r;
  logic signed [DATA_W-1:0]   w_r;
  logic signed [ACC_W-1:0]    acc1_r;
  logic signed [ACC_W-1:0]    acc2_r;
  logic [STG_W-1:0]           stage_r;
  logic [2:0]                 term_r;
  logic                       pend_vld_r;
  logic                       pend_dst_r;

  // Coefficient table and history store.
  logic signed [DATA_W-1:0] coef_r [COEFF_DEPTH];
  logic [2*DATA_W-1:0]      hist_mem [HIST_ROWS];
  logic [2*DATA_W-1:0]      hist_q_r;
  logic                     hist_qv_r;
  logic [HIST_ROWS-1:0]     hist_vld_r;

  logic                     out_valid_r;
  out_item_t                out_r;

  // Combinational helpers.
  logic                     in_acc;
  logic                     butter;
  logic [CNT_W-1:0]         nstg;
  logic                     stage_last;
  logic [2:0]               last_term;
  logic [ROW_W-1:0]         row;
  logic signed [DATA_W-1:0] h0, h1, coef;
  logic [2:0]               term_off;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ACC_W-1:0]  term_add;
  logic signed [DATA_W-1:0] w_sat;
  logic signed [33:0]       kd, k34, thr34;
  logic                     bypass, mute;
  logic                     out_load;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != ST_IDLE);
  assign butter     = (mode_r == MODE_BUTTERWORTH);
  assign last_term  = butter ? TERM_C3 : TERM_C1;
  assign row        = {trk_r, stage_r};
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;
  assign out_load   = (state_r == ST_OUTP) && (!out_valid_r || !out_stall);

  // Active section count: zero acts as one, the top is clamped.
  always_comb begin
    if (stage_count_r == 3'd0) begin
      nstg = CNT_W'(1);
    end else if (CNT_W'(stage_count_r) > CNT_W'(MAX_STAGES)) begin
      nstg = CNT_W'(MAX_STAGES);
    end else begin
      nstg = CNT_W'(stage_count_r);
    end
  end

  assign stage_last = ((CNT_W'(stage_r) + CNT_W'(1)) == nstg);

  // Bypass and mute tests on the combined gain.
  assign k34    = {{2{k_r[DATA_W-1]}}, k_r};
  assign kd     = k34 - {{2{ONE_Q28[DATA_W-1]}}, ONE_Q28};
  assign thr34  = {3'b000, thr_r};
  assign bypass = (kd < thr34) && (kd > -thr34);
  assign mute   = (k34 < thr34) && (k34 > -thr34) && (stage_count_r < 3'd2);

  // History words of the current row; a row never written reads as zero.
  assign h0 = hist_qv_r ? hist_q_r[DATA_W-1:0]        : '0;
  assign h1 = hist_qv_r ? hist_q_r[2*DATA_W-1:DATA_W] : '0;

  // Coefficient for the current term of the current section.
  assign term_off = term_r - TERM_C0;
  assign coef     = coef_r[{stage_r, term_off[1:0]}];

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == ST_KMUL) begin
      mul_a = {base_gain_r[DATA_W-1], base_gain_r};
      mul_b = diff_r;
    end else if (state_r == ST_MAC) begin
      unique case (term_r)
        TERM_GAIN: begin
          mul_a = {y_r[DATA_W-1], y_r};
          mul_b = (stage_r == '0) ? {k_r[DATA_W-1], k_r} : {1'b0, ONE_Q28};
        end
        TERM_C0, TERM_C2: begin
          mul_a = {h0[DATA_W-1], h0};
          mul_b = {coef[DATA_W-1], coef};
        end
        TERM_C1, TERM_C3: begin
          mul_a = {h1[DATA_W-1], h1};
          mul_b = {coef[DATA_W-1], coef};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  cbq_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (mul_p)
  );

  // Rounded product in sample units: floor(p / 2^28) plus the half bit.
  assign term_add = {{(ACC_W-TERM_W){mul_p[PROD_W-1]}}, mul_p[PROD_W-1:FRAC_W]}
                  + {{(ACC_W-1){1'b0}}, mul_p[FRAC_W-1]};

  assign w_sat = sat32(acc1_r);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.op == OP_SAMPLE) begin
          state_nxt = ST_KMUL;
        end
      end
      ST_KMUL:  state_nxt = ST_KSAT;
      ST_KSAT:  state_nxt = ST_KCHK;
      ST_KCHK:  state_nxt = (bypass || mute) ? ST_OUTP : ST_MAC;
      ST_MAC: begin
        if (term_r == last_term) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_WSAT;
      ST_WSAT:  state_nxt = ST_YSUM;
      ST_YSUM:  state_nxt = stage_last ? ST_OUTP : ST_MAC;
      ST_OUTP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and history valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_BUTTERWORTH;
      base_gain_r   <= ONE_Q28;
      high_gain_r   <= ONE_Q28;
      low_gain_r    <= '0;
      stage_count_r <= 3'd1;
      thr_r         <= THR_W'(4247);
      stage_r       <= '0;
      term_r        <= TERM_GAIN;
      pend_vld_r    <= 1'b0;
      pend_dst_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      hist_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FILTER_MODE:    mode_r        <= cfg_wdata[1:0];
          CFG_BASE_GAIN:      base_gain_r   <= cfg_wdata;
          CFG_HIGH_GAIN:      high_gain_r   <= cfg_wdata;
          CFG_LOW_GAIN:       low_gain_r    <= cfg_wdata;
          CFG_STAGE_COUNT:    stage_count_r <= cfg_wdata[2:0];
          CFG_NEAR_THRESHOLD: thr_r         <= cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end

      if (in_acc) begin
        stage_r <= '0;
      end else if (state_r == ST_YSUM) begin
        stage_r <= stage_r + STG_W'(1);
      end

      if (state_r == ST_KCHK || state_r == ST_YSUM) begin
        term_r <= TERM_GAIN;
      end else if (state_r == ST_MAC) begin
        term_r <= term_r + 3'd1;
      end

      pend_vld_r <= (state_r == ST_MAC);
      pend_dst_r <= (term_r >= TERM_C2);

      if (state_r == ST_WSAT) begin
        hist_vld_r[row] <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == OP_SAMPLE) begin
      trk_r  <= in_data.track[TRK_W-1:0];
      x_r    <= in_data.sample_in;
      last_r <= in_data.block_last;
      if (mode_r == MODE_BESSEL) begin
        diff_r <= {high_gain_r[DATA_W-1], high_gain_r} - {low_gain_r[DATA_W-1], low_gain_r};
      end else begin
        diff_r <= {high_gain_r[DATA_W-1], high_gain_r};
      end
    end

    if (in_acc && in_data.op == OP_COEFF) begin
      coef_r[in_data.coeff_index[CIDX_W-1:0]] <= in_data.coeff_value;
    end

    // Combined gain, floored back to Q4.28 and saturated.
    if (state_r == ST_KSAT) begin
      k_r <= sat32({{(ACC_W-TERM_W){mul_p[PROD_W-1]}}, mul_p[PROD_W-1:FRAC_W]});
    end

    // Section input: the sample (zero on mute unless bypass) for the first section, else the section output.
    if (state_r == ST_KCHK) begin
      y_r    <= (mute && !bypass) ? '0 : {{(DATA_W-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (state_r == ST_YSUM) begin
      y_r    <= butter ? sat32({{(ACC_W-DATA_W){w_r[DATA_W-1]}}, w_r} + acc2_r) : w_r;
      acc1_r <= '0;
      acc2_r <= '0;
    end else if (pend_vld_r) begin
      if (pend_dst_r) begin
        acc2_r <= acc2_r + term_add;
      end else begin
        acc1_r <= acc1_r + term_add;
      end
    end

    if (state_r == ST_WSAT) begin
      w_r <= w_sat;
    end

    if (out_load) begin
      out_r.sample_out     <= sat24(y_r);
      out_r.block_last_out <= last_r;
    end
  end

  // History store: one registered read and one write per cycle, row = {h1, h0}.
  always_ff @(posedge clk) begin
    hist_q_r  <= hist_mem[row];
    hist_qv_r <= hist_vld_r[row];
    if (state_r == ST_WSAT) begin
      hist_mem[row] <= {h0, w_sat};
    end
  end

endmodule

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbq_pkg::*;

  // Mode code that the package does not name.
  localparam logic [1:0] MODE_RESERVED  = 2'd3;

  // Register reset values and limits.
  localparam logic [THR_W-1:0] THR_RESET = 31'd4247;
  localparam longint WORD_MAX   = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN   = -(longint'(1) <<< (DATA_W - 1));
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));

  // Idle time waited after the last expected result has come back.
  localparam int SETTLE_CYCLES = 48;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_item_t             in_data   = '0;
  logic                 out_stall = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_stall;
  logic                 out_valid;
  out_item_t            out_data;

  cascaded_biquad_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [1:0]               mode_q   = 2'd0;
  logic signed [DATA_W-1:0] base_q   = ONE_Q28;
  logic signed [DATA_W-1:0] high_q   = ONE_Q28;
  logic signed [DATA_W-1:0] low_q    = '0;
  logic [2:0]               stages_q = 3'd1;
  logic [THR_W-1:0]         thr_q    = THR_RESET;

  // Shadow copy of the section history and the coefficient table.
  int hist_words [MAX_TRACKS][MAX_STAGES][2] = '{default: 0};
  int coeff_words [COEFF_DEPTH] = '{default: 0};

  out_item_t expected_outputs[$];
  int        error_count   = 0;
  int        in_idle_pct   = 0;
  int        out_stall_pct = 0;
  bit        coeffs_wild   = 1'b0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Product of a sample-unit value and a Q4.28 word, rounded half up to sample units.
  function automatic longint mul_round(input longint a, input longint q);
    return (a * q + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  // Gain of the first section, from the current register settings.
  function automatic longint first_gain();
    longint diff;
    if (mode_q == MODE_BESSEL) begin
      diff = longint'(high_q) - longint'(low_q);
    end else begin
      diff = longint'(high_q);
    end
    return clamp((longint'(base_q) * diff) >>> FRAC_W, WORD_MIN, WORD_MAX);
  endfunction

  // Run one sample through the cascade and queue the expected output.
  function automatic void predict_sample(input in_item_t it);
    longint    k, y, g, w, h0, h1;
    int        n, s, base_slot;
    out_item_t res;
    k = first_gain();
    n = stages_q;
    if (n == 0) n = 1;
    if (n > MAX_STAGES) n = MAX_STAGES;
    y = longint'($signed(it.sample_in));
    if (abs_val(k - longint'(ONE_Q28)) < longint'(thr_q)) begin
      // Unity gain: the sample passes straight through.
    end else if (abs_val(k) < longint'(thr_q) && stages_q < 2) begin
      y = 0;
    end else begin
      for (s = 0; s < n; s++) begin
        base_slot = s * 4;
        h0 = hist_words[it.track][s][0];
        h1 = hist_words[it.track][s][1];
        g  = (s == 0) ? mul_round(y, k) : y;
        w  = clamp(g + mul_round(h0, coeff_words[base_slot])
                   + mul_round(h1, coeff_words[base_slot + 1]), WORD_MIN, WORD_MAX);
        if (mode_q == MODE_BUTTERWORTH) begin
          y = clamp(w + mul_round(h0, coeff_words[base_slot + 2])
                    + mul_round(h1, coeff_words[base_slot + 3]), WORD_MIN, WORD_MAX);
        end else begin
          y = w;
        end
        hist_words[it.track][s][1] = int'(h0);
        hist_words[it.track][s][0] = int'(w);
      end
      y = clamp(y, SAMPLE_MIN, SAMPLE_MAX);
    end
    res.sample_out     = y[SAMPLE_W-1:0];
    res.block_last_out = it.block_last;
    expected_outputs.push_back(res);
  endfunction

  // Update the shadow state for one accepted transaction.
  function automatic void apply_item(input in_item_t it);
    if (it.op == OP_COEFF) begin
      coeff_words[it.coeff_index] = int'(it.coeff_value);
    end else begin
      predict_sample(it);
    end
  endfunction

  // Drive one transaction, with random idle cycles ahead of it.
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FILTER_MODE:    mode_q   = value[1:0];
      CFG_BASE_GAIN:      base_q   = value;
      CFG_HIGH_GAIN:      high_q   = value;
      CFG_LOW_GAIN:       low_q    = value;
      CFG_STAGE_COUNT:    stages_q = value[2:0];
      CFG_NEAR_THRESHOLD: thr_q    = value[THR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t sample_item(input logic [2:0] trk,
                                           input logic signed [SAMPLE_W-1:0] value,
                                           input logic last);
    in_item_t it;
    it.op          = OP_SAMPLE;
    it.track       = trk;
    it.sample_in   = value;
    it.coeff_index = 4'($urandom);
    it.coeff_value = $urandom;
    it.block_last  = last;
    return it;
  endfunction

  function automatic in_item_t coeff_item(input logic [3:0] idx,
                                          input logic signed [DATA_W-1:0] value);
    in_item_t it;
    it.op          = OP_COEFF;
    it.track       = 3'($urandom);
    it.sample_in   = 24'($urandom);
    it.coeff_index = idx;
    it.coeff_value = value;
    it.block_last  = 1'($urandom);
    return it;
  endfunction

  // Feedback taps stay within a quarter so the sections stay stable.
  function automatic logic signed [DATA_W-1:0] stable_coeff(input logic [3:0] idx);
    if (idx[1] == 1'b0) begin
      return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    end
    return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 131071) - 65536);
      2: return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
      default: return 24'($urandom_range(0, 2097151) - 1048576);
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] random_gain();
    case ($urandom_range(7))
      0: return ONE_Q28;
      1: return $urandom;
      2: return '0;
      default: return $urandom_range(0, 32'h2000_0000) - 32'h0800_0000;
    endcase
  endfunction

  // Mostly samples; some coefficient writes, a few of them full range.
  function automatic in_item_t random_item(output bit wild);
    in_item_t it;
    wild = 1'b0;
    if ($urandom_range(99) < 10) begin
      it = coeff_item(4'($urandom), '0);
      wild = ($urandom_range(5) == 0);
      it.coeff_value = wild ? $urandom : stable_coeff(it.coeff_index);
    end else begin
      it = sample_item(3'($urandom), random_sample(), 1'($urandom_range(7) == 0));
    end
    return it;
  endfunction

  task automatic load_stable_coeffs();
    int i;
    for (i = 0; i < COEFF_DEPTH; i++) begin
      send_item(coeff_item(4'(i), stable_coeff(4'(i))));
    end
  endtask

  task automatic randomize_config();
    logic signed [DATA_W-1:0] base, high, low;
    logic [THR_W-1:0]         thr;
    int                       pick;
    base = random_gain();
    high = random_gain();
    low  = random_gain();
    case ($urandom_range(15))
      0: thr = '0;
      1: thr = '1;
      2: thr = 31'($urandom);
      default: thr = 31'($urandom_range(0, 8191));
    endcase
    pick = $urandom_range(9);
    if (pick == 0) begin
      // Unity gain, so the sample bypasses the filter unless the threshold is zero.
      base = ONE_Q28;
      high = ONE_Q28;
      low  = '0;
    end else if (pick == 1) begin
      // Zero gain mutes the output if the section count is below two.
      base = '0;
    end
    write_reg(CFG_FILTER_MODE, $urandom_range(3));
    write_reg(CFG_BASE_GAIN, base);
    write_reg(CFG_HIGH_GAIN, high);
    write_reg(CFG_LOW_GAIN, low);
    write_reg(CFG_STAGE_COUNT, $urandom_range(7));
    write_reg(CFG_NEAR_THRESHOLD, thr);
  endtask

  // Every coefficient slot gets a value before any section can read it.
  task automatic test_coefficient_load();
    load_stable_coeffs();
  endtask

  // Reset settings give unity gain, so samples pass through untouched.
  task automatic test_bypass_defaults();
    send_item(sample_item(3'd0, 24'h7F_FFFF, 1'b1));
    send_item(sample_item(3'd7, 24'h80_0000, 1'b0));
  endtask

  // Zero gain with one section and with a section count of zero.
  task automatic test_mute();
    wait_until_idle();
    write_reg(CFG_BASE_GAIN, '0);
    send_item(sample_item(3'd3, 24'h12_3456, 1'b0));
    wait_until_idle();
    write_reg(CFG_STAGE_COUNT, 3'd0);
    send_item(sample_item(3'd4, 24'h80_0000, 1'b1));
  endtask

  // Four sections with feed-forward taps, history carried on one track.
  task automatic test_butterworth_cascade();
    wait_until_idle();
    write_reg(CFG_FILTER_MODE, MODE_BUTTERWORTH);
    write_reg(CFG_BASE_GAIN, ONE_Q28);
    write_reg(CFG_HIGH_GAIN, 32'h0800_0000);
    write_reg(CFG_STAGE_COUNT, 3'd4);
    send_item(sample_item(3'd5, 24'h7F_FFFF, 1'b0));
    send_item(sample_item(3'd5, 24'h80_0000, 1'b1));
  endtask

  // Bessel gain uses the difference of the band gains.
  task automatic test_bessel_gain();
    wait_until_idle();
    write_reg(CFG_FILTER_MODE, MODE_BESSEL);
    write_reg(CFG_HIGH_GAIN, 32'h1800_0000);
    write_reg(CFG_LOW_GAIN, 32'h0400_0000);
    write_reg(CFG_STAGE_COUNT, 3'd2);
    send_item(sample_item(3'd1, random_sample(), 1'b0));
    send_item(sample_item(3'd1, random_sample(), 1'b1));
  endtask

  // The undefined mode acts as recursive-only, and too many sections act as the maximum.
  task automatic test_reserved_mode();
    wait_until_idle();
    write_reg(CFG_FILTER_MODE, MODE_RESERVED);
    write_reg(CFG_STAGE_COUNT, 3'd7);
    send_item(sample_item(3'd2, random_sample(), 1'b0));
    send_item(sample_item(3'd6, random_sample(), 1'b1));
  endtask

  // Extreme gains and coefficients drive the gain and output saturation.
  task automatic test_saturation_extremes();
    wait_until_idle();
    write_reg(CFG_FILTER_MODE, MODE_BUTTERWORTH);
    write_reg(CFG_STAGE_COUNT, 3'd1);
    write_reg(CFG_BASE_GAIN, 32'h8000_0000);
    write_reg(CFG_HIGH_GAIN, 32'h8000_0000);
    send_item(coeff_item(4'd0, 32'h7FFF_FFFF));
    send_item(coeff_item(4'd1, 32'h8000_0000));
    coeffs_wild = 1'b1;
    send_item(sample_item(3'd0, 24'h80_0000, 1'b0));
    wait_until_idle();
    write_reg(CFG_FILTER_MODE, MODE_BESSEL);
    write_reg(CFG_BASE_GAIN, 32'h7FFF_FFFF);
    write_reg(CFG_HIGH_GAIN, 32'h7FFF_FFFF);
    write_reg(CFG_LOW_GAIN, 32'h8000_0000);
    write_reg(CFG_NEAR_THRESHOLD, 31'h7FFF_FFFF);
    send_item(sample_item(3'd0, 24'h7F_FFFF, 1'b1));
    wait_until_idle();
    write_reg(CFG_NEAR_THRESHOLD, '0);
    send_item(sample_item(3'd0, 24'h7F_FFFF, 1'b0));
  endtask

  // Random traffic under each idling pattern, with a fresh setting per chunk.
  task automatic test_random_traffic();
    int       phase, chunk, i;
    bit       wild;
    in_item_t it;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 62; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 62; end
        default: begin in_idle_pct = 15; out_stall_pct = 15; end
      endcase
      for (chunk = 0; chunk < 6; chunk++) begin
        wait_until_idle();
        randomize_config();
        if (coeffs_wild) begin
          load_stable_coeffs();
          coeffs_wild = 1'b0;
        end
        for (i = 0; i < 40; i++) begin
          it = random_item(wild);
          coeffs_wild |= wild;
          send_item(it);
        end
      end
    end
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Compare each result transaction with the oldest expected output.
  always @(posedge clk) begin : check_outputs
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        $error("Unexpected result transaction: sample_out %0d, block_last_out %0b",
               $signed(out_data.sample_out), out_data.block_last_out);
        error_count++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          $error("sample_out mismatch: expected %0d, actual %0d",
                 $signed(want.sample_out), $signed(out_data.sample_out));
          error_count++;
        end
        if (out_data.block_last_out !== want.block_last_out) begin
          $error("block_last_out mismatch: expected %0b, actual %0b",
                 want.block_last_out, out_data.block_last_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_coefficient_load();
    test_bypass_defaults();
    test_mute();
    test_butterworth_cascade();
    test_bessel_gain();
    test_reserved_mode();
    test_saturation_extremes();
    test_random_traffic();
    wait_until_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard limit on run time.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
